// ===== rtl/core/ajl_pkg.sv =====
package ajl_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int AVG_W        = 32;
  localparam int GAP_BITS     = 24;
  localparam int WEIGHT_W     = 8;
  localparam int WEIGHT_SHIFT = 8;
  localparam int LAT_W        = 10;
  localparam int GAIN_W       = 4;
  localparam int HYST_W       = 8;
  localparam int PERIOD_W     = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [GAP_BITS-1:0] GAP_MAX = '1;
  localparam logic [AVG_W-1:0]    AVG_MAX = '1;

  // adjust period is given in ms, timestamps in us
  localparam int PERIOD_SCALE = 1000;
  localparam int PERIOD_US_W  = PERIOD_W + 10;

  // ema datapath: weight * (sample - avg), signed
  localparam int DIFF_W     = AVG_W + 2;
  localparam int PROD_W     = DIFF_W + WEIGHT_W + 1;
  localparam int EMA_ROUND  = 1 << (WEIGHT_SHIFT - 1);

  // target: gain * jitter scaled to ms, divided by 1000 through a reciprocal
  localparam int T_W         = AVG_W + GAIN_W;
  localparam int HALF_MS     = 500;
  localparam int Q_LIMIT     = 1 << LAT_W;
  localparam int X_LIMIT     = Q_LIMIT * PERIOD_SCALE;
  localparam int X_W         = 20;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + PERIOD_SCALE - 1) / PERIOD_SCALE;
  localparam int RECIP_W     = 21;
  localparam int Q_W         = LAT_W + 1;
  localparam int TGT_W       = LAT_W + 2;

  localparam logic [LAT_W-1:0] LAT_RESET = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA   = 3'd0,
    CFG_BETA    = 3'd1,
    CFG_BASE    = 3'd2,
    CFG_GAIN    = 3'd3,
    CFG_MIN     = 3'd4,
    CFG_MAX     = 3'd5,
    CFG_HYST    = 3'd6,
    CFG_PERIOD  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] alpha;
    logic [WEIGHT_W-1:0] beta;
    logic [LAT_W-1:0]    base_lat;
    logic [GAIN_W-1:0]   gain;
    logic [LAT_W-1:0]    min_lat;
    logic [LAT_W-1:0]    max_lat;
    logic [HYST_W-1:0]   hyst;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic g_mul;
    logic g_add;
    logic dev;
    logic j_mul;
    logic j_add;
    logic t_mul;
    logic t_div;
    logic t_quo;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_item;
    logic check_now;
    logic check_held;
  } dp_status_t;

endpackage

// ===== rtl/core/ajl_in_if.sv =====
interface ajl_in_if #(
  parameter int TIME_WIDTH = ajl_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] arrival_time_us;

  modport source (output valid, output arrival_time_us, input ready);
  modport sink (input valid, input arrival_time_us, output ready);
endinterface

// ===== rtl/core/ajl_out_if.sv =====
interface ajl_out_if;
  logic                       valid;
  logic                       ready;
  logic [ajl_pkg::LAT_W-1:0]  latency_ms;
  logic                       latency_updated;
  logic [ajl_pkg::AVG_W-1:0]  jitter_q8;
  logic [ajl_pkg::AVG_W-1:0]  gap_average_q8;

  modport source (output valid, output latency_ms, output latency_updated,
                  output jitter_q8, output gap_average_q8, input ready);
  modport sink (input valid, input latency_ms, input latency_updated,
                input jitter_q8, input gap_average_q8, output ready);
endinterface

// ===== rtl/core/ajl_ctrl.sv =====
module ajl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ajl_pkg::dp_status_t    status_i,
  output ajl_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_PREP  = 11'b000_0000_0010,
    S_GMUL  = 11'b000_0000_0100,
    S_GADD  = 11'b000_0000_1000,
    S_DEV   = 11'b000_0001_0000,
    S_JMUL  = 11'b000_0010_0000,
    S_JADD  = 11'b000_0100_0000,
    S_TMUL  = 11'b000_1000_0000,
    S_TDIV  = 11'b001_0000_0000,
    S_TQUO  = 11'b010_0000_0000,
    S_APPLY = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        if (!status_i.first_item) begin
          state_d = S_GMUL;
        end else if (status_i.check_now) begin
          state_d = S_TMUL;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_GMUL: begin
        cmd_o.g_mul = 1'b1;
        state_d     = S_GADD;
      end
      S_GADD: begin
        cmd_o.g_add = 1'b1;
        state_d     = S_DEV;
      end
      S_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = S_JMUL;
      end
      S_JMUL: begin
        cmd_o.j_mul = 1'b1;
        state_d     = S_JADD;
      end
      S_JADD: begin
        cmd_o.j_add = 1'b1;
        state_d     = status_i.check_held ? S_TMUL : S_APPLY;
      end
      S_TMUL: begin
        cmd_o.t_mul = 1'b1;
        state_d     = S_TDIV;
      end
      S_TDIV: begin
        cmd_o.t_div = 1'b1;
        state_d     = S_TQUO;
      end
      S_TQUO: begin
        cmd_o.t_quo = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        // state and result are written together once the output slot is free
        if (slot_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_PREP)
    else $error("accepted item did not start processing");

  a_apply_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_q)
    else $error("applied result not presented");

  a_apply_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY && out_valid_q && !out_ready_i |=> state_q == S_APPLY)
    else $error("result overwrote a pending item");
`endif

endmodule

// ===== rtl/core/ajl_dp.sv =====
module ajl_dp #(
  parameter int TIME_WIDTH = ajl_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = ajl_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ajl_pkg::cfg_t              cfg_i,
  input  ajl_pkg::ctrl_cmd_t         cmd_i,
  output ajl_pkg::dp_status_t        status_o,
  input  logic [TIME_WIDTH-1:0]      arrival_i,
  output logic [ajl_pkg::LAT_W-1:0]  latency_o,
  output logic                       updated_o,
  output logic [ajl_pkg::AVG_W-1:0]  jitter_o,
  output logic [ajl_pkg::AVG_W-1:0]  gap_o
);

  localparam int AVG_W  = ajl_pkg::AVG_W;
  localparam int LAT_W  = ajl_pkg::LAT_W;
  localparam int GAP_B  = ajl_pkg::GAP_BITS;
  localparam int WIDE_W = (TIME_WIDTH > GAP_B) ? TIME_WIDTH : GAP_B;
  localparam int DX_W   = (GAP_B + FRAC_BITS > AVG_W) ? GAP_B + FRAC_BITS : AVG_W + 1;
  localparam int CHK_W  = (TIME_WIDTH > ajl_pkg::PERIOD_US_W) ?
                          TIME_WIDTH : ajl_pkg::PERIOD_US_W;
  localparam int PROD_W = ajl_pkg::PROD_W;
  localparam int DIFF_W = ajl_pkg::DIFF_W;
  localparam int T_W    = ajl_pkg::T_W;
  localparam int X_W    = ajl_pkg::X_W;
  localparam int Q_W    = ajl_pkg::Q_W;
  localparam int TGT_W  = ajl_pkg::TGT_W;
  localparam int RP_W   = X_W + ajl_pkg::RECIP_W;

  logic [TIME_WIDTH-1:0] now_q, last_arrival_q, last_adj_q;
  logic                  seen_q, adj_started_q, check_q;
  logic [AVG_W-1:0]      d_q, gap_q, jit_q, dev_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [T_W-1:0]        t_q;
  logic [X_W-1:0]        x_q;
  logic                  big_q;
  logic [Q_W-1:0]        q_q;
  logic [LAT_W-1:0]      latency_q;
  logic [LAT_W-1:0]      lat_out_q;
  logic                  upd_out_q;
  logic [AVG_W-1:0]      jit_out_q, gap_out_q;

  // gap sample
  logic [TIME_WIDTH-1:0] delta;
  logic [WIDE_W-1:0]     delta_x;
  logic [GAP_B-1:0]      gap_s;
  logic [DX_W-1:0]       d_x;
  logic [AVG_W-1:0]      d_s;

  assign delta   = now_q - last_arrival_q;
  assign delta_x = WIDE_W'(delta);
  assign gap_s   = (delta_x > WIDE_W'(ajl_pkg::GAP_MAX)) ? ajl_pkg::GAP_MAX
                                                         : delta_x[GAP_B-1:0];
  assign d_x     = DX_W'(gap_s) << FRAC_BITS;
  assign d_s     = (d_x > DX_W'(ajl_pkg::AVG_MAX)) ? ajl_pkg::AVG_MAX : d_x[AVG_W-1:0];

  // adjust clock
  logic [TIME_WIDTH-1:0] ref_time, elapsed;
  logic [CHK_W-1:0]      period_us;
  logic                  check_s;

  assign ref_time  = adj_started_q ? last_adj_q : now_q;
  assign elapsed   = now_q - ref_time;
  assign period_us = CHK_W'(cfg_i.period) * CHK_W'(ajl_pkg::PERIOD_SCALE);
  assign check_s   = CHK_W'(elapsed) >= period_us;

  assign status_o.first_item = !seen_q;
  assign status_o.check_now  = check_s;
  assign status_o.check_held = check_q;

  // shared ema unit, gap phase or jitter phase
  logic                     jit_phase;
  logic [AVG_W-1:0]         ema_avg, ema_sample, ema_new, ema_res;
  logic signed [8:0]        ema_w;
  logic signed [DIFF_W-1:0] ema_diff;
  logic signed [PROD_W-1:0] ema_prod, ema_round, ema_step;

  assign jit_phase  = cmd_i.j_mul || cmd_i.j_add;
  assign ema_avg    = jit_phase ? jit_q : gap_q;
  assign ema_sample = jit_phase ? dev_q : d_q;
  assign ema_w      = $signed({1'b0, (jit_phase ? cfg_i.beta : cfg_i.alpha)});
  assign ema_diff   = $signed({2'b00, ema_sample}) - $signed({2'b00, ema_avg});
  assign ema_prod   = ema_w * ema_diff;
  assign ema_round  = prod_q + PROD_W'(ajl_pkg::EMA_ROUND);
  assign ema_step   = ema_round >>> ajl_pkg::WEIGHT_SHIFT;
  assign ema_new    = ema_avg + ema_step[AVG_W-1:0];
  // an empty average takes the sample as it is
  assign ema_res    = (ema_avg == '0) ? ema_sample : ema_new;

  // target latency
  logic [T_W:0]       x_wide;
  logic [RP_W-1:0]    recip_prod;
  logic [Q_W-1:0]     q_s;
  logic [TGT_W-1:0]   tgt_sum, tgt_lo, tgt_c;
  logic [LAT_W-1:0]   tgt;
  logic [LAT_W-1:0]   lat_diff;
  logic               upd_s;

  assign x_wide     = ({1'b0, t_q} >> FRAC_BITS) + (T_W+1)'(ajl_pkg::HALF_MS);
  assign recip_prod = RP_W'(x_q) * RP_W'(ajl_pkg::RECIP);
  assign q_s        = big_q ? Q_W'(ajl_pkg::Q_LIMIT)
                            : recip_prod[ajl_pkg::RECIP_SHIFT+Q_W-1:ajl_pkg::RECIP_SHIFT];
  assign tgt_sum    = TGT_W'(cfg_i.base_lat) + TGT_W'(q_q);
  // min first, then max, so max wins on a crossed pair
  assign tgt_lo     = (tgt_sum < TGT_W'(cfg_i.min_lat)) ? TGT_W'(cfg_i.min_lat) : tgt_sum;
  assign tgt_c      = (tgt_lo > TGT_W'(cfg_i.max_lat)) ? TGT_W'(cfg_i.max_lat) : tgt_lo;
  assign tgt        = tgt_c[LAT_W-1:0];
  assign lat_diff   = (tgt >= latency_q) ? tgt - latency_q : latency_q - tgt;
  assign upd_s      = check_q && (lat_diff >= LAT_W'(cfg_i.hyst));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q         <= 1'b0;
      adj_started_q  <= 1'b0;
      last_arrival_q <= '0;
      last_adj_q     <= '0;
      gap_q          <= '0;
      jit_q          <= '0;
      latency_q      <= ajl_pkg::LAT_RESET;
    end else begin
      if (cmd_i.prep) begin
        seen_q         <= 1'b1;
        adj_started_q  <= 1'b1;
        last_arrival_q <= now_q;
        if (!adj_started_q || check_s) begin
          last_adj_q <= now_q;
        end
      end
      if (cmd_i.g_add) begin
        gap_q <= ema_res;
      end
      if (cmd_i.j_add) begin
        jit_q <= ema_res;
      end
      if (cmd_i.apply && upd_s) begin
        latency_q <= tgt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= arrival_i;
    end
    if (cmd_i.prep) begin
      d_q     <= d_s;
      check_q <= check_s;
    end
    if (cmd_i.g_mul || cmd_i.j_mul) begin
      prod_q <= ema_prod;
    end
    if (cmd_i.dev) begin
      dev_q <= (d_q >= gap_q) ? d_q - gap_q : gap_q - d_q;
    end
    if (cmd_i.t_mul) begin
      t_q <= T_W'(cfg_i.gain) * T_W'(jit_q);
    end
    if (cmd_i.t_div) begin
      big_q <= x_wide >= (T_W+1)'(ajl_pkg::X_LIMIT);
      x_q   <= x_wide[X_W-1:0];
    end
    if (cmd_i.t_quo) begin
      q_q <= q_s;
    end
    if (cmd_i.apply) begin
      lat_out_q <= upd_s ? tgt : latency_q;
      upd_out_q <= upd_s;
      jit_out_q <= jit_q;
      gap_out_q <= gap_q;
    end
  end

  assign latency_o = lat_out_q;
  assign updated_o = upd_out_q;
  assign jitter_o  = jit_out_q;
  assign gap_o     = gap_out_q;

`ifndef ASSERT_OFF
  a_start_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == adj_started_q)
    else $error("arrival and adjust clocks out of step");

  a_hold_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && !upd_s |=> $stable(latency_q))
    else $error("latency changed without an update");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && upd_s && cfg_i.min_lat <= cfg_i.max_lat |=>
      latency_q >= $past(cfg_i.min_lat) && latency_q <= $past(cfg_i.max_lat))
    else $error("updated latency outside clamp range");
`endif

endmodule

// ===== rtl/core/adaptive_jitter_latency.sv =====
// Adaptive jitter-buffer latency controller. Each input item is one packet arrival
// timestamp in microseconds; each arrival yields exactly one result item with the
// current latency, an update strobe and the gap and jitter averages (Q8 us). Items
// are handled one at a time by a sequencer around a single shared EMA multiplier.
// A first arrival after reset runs prep and apply if no adjustment check is due, or
// prep, target multiply, reciprocal divide by 1000 and quotient before apply if one
// is due. A later arrival runs prep, gap multiply and add, deviation and jitter
// multiply and add, then the target steps too when an adjustment check runs; clamp
// and hysteresis compare come with apply. The result item is presented in the same
// cycle in which the next arrival can first be taken; if the output register still
// holds an untaken result, the sequencer waits in its last cycle until that item
// leaves. A new arrival is accepted while the previous result still waits in the
// output register. The user must write configuration through cfg_we_i / cfg_idx_i /
// cfg_data_i only while no item is in flight; the block itself does not enforce this.
module adaptive_jitter_latency #(
  parameter int TIME_WIDTH = ajl_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = ajl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ajl_in_if.sink                        in_i,
  ajl_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ajl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ajl_pkg::CFG_W-1:0]     cfg_data_i
);

  ajl_pkg::cfg_t       cfg_q;
  ajl_pkg::ctrl_cmd_t  cmd;
  ajl_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha    <= 8'd26;
      cfg_q.beta     <= 8'd51;
      cfg_q.base_lat <= 10'd50;
      cfg_q.gain     <= 4'd3;
      cfg_q.min_lat  <= 10'd50;
      cfg_q.max_lat  <= 10'd300;
      cfg_q.hyst     <= 8'd10;
      cfg_q.period   <= 16'd1000;
    end else if (cfg_we_i) begin
      case (ajl_pkg::cfg_idx_e'(cfg_idx_i))
        ajl_pkg::CFG_ALPHA:  cfg_q.alpha    <= cfg_data_i[ajl_pkg::WEIGHT_W-1:0];
        ajl_pkg::CFG_BETA:   cfg_q.beta     <= cfg_data_i[ajl_pkg::WEIGHT_W-1:0];
        ajl_pkg::CFG_BASE:   cfg_q.base_lat <= cfg_data_i[ajl_pkg::LAT_W-1:0];
        ajl_pkg::CFG_GAIN:   cfg_q.gain     <= cfg_data_i[ajl_pkg::GAIN_W-1:0];
        ajl_pkg::CFG_MIN:    cfg_q.min_lat  <= cfg_data_i[ajl_pkg::LAT_W-1:0];
        ajl_pkg::CFG_MAX:    cfg_q.max_lat  <= cfg_data_i[ajl_pkg::LAT_W-1:0];
        ajl_pkg::CFG_HYST:   cfg_q.hyst     <= cfg_data_i[ajl_pkg::HYST_W-1:0];
        ajl_pkg::CFG_PERIOD: cfg_q.period   <= cfg_data_i[ajl_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  ajl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ajl_dp #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .status_o  (status),
    .arrival_i (in_i.arrival_time_us),
    .latency_o (out_o.latency_ms),
    .updated_o (out_o.latency_updated),
    .jitter_o  (out_o.jitter_q8),
    .gap_o     (out_o.gap_average_q8)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS      = ajl_pkg::FRAC_BITS_DEF;
  localparam int LAT_W          = ajl_pkg::LAT_W;
  localparam int AVG_W          = ajl_pkg::AVG_W;
  localparam int CFG_IDX_W      = ajl_pkg::CFG_IDX_W;
  localparam int CFG_W          = ajl_pkg::CFG_W;
  localparam int WEIGHT_W       = ajl_pkg::WEIGHT_W;
  localparam int GAIN_W         = ajl_pkg::GAIN_W;
  localparam int HYST_W         = ajl_pkg::HYST_W;
  localparam int PERIOD_W       = ajl_pkg::PERIOD_W;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 155;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int MAX_PRINTED    = 100;
  localparam logic [31:0] GAP_SAT = {8'h00, ajl_pkg::GAP_MAX};

  typedef struct {
    logic [LAT_W-1:0] latency;
    logic             updated;
    logic [AVG_W-1:0] jitter;
    logic [AVG_W-1:0] gap_avg;
  } arrival_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  ajl_in_if #(.TIME_WIDTH(ajl_pkg::TIME_WIDTH_DEF)) in_ch ();
  ajl_out_if out_ch ();

  adaptive_jitter_latency i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  ajl_pkg::cfg_t    est_cfg;
  logic             est_seen;
  logic [31:0]      est_last_time;
  logic [AVG_W-1:0] est_gap_avg;
  logic [AVG_W-1:0] est_jitter_avg;
  logic [LAT_W-1:0] est_latency;
  logic             est_adj_armed;
  logic [31:0]      est_adj_time;

  arrival_result_t pending_results[$];
  int              error_count = 0;
  int              cycle_count = 0;
  int              stall_left = 0;
  bit              steady_flow = 1'b0;
  logic [31:0]     next_time;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  function automatic logic [AVG_W-1:0] ema_next(input logic [AVG_W-1:0] avg,
                                                input logic [AVG_W-1:0] sample,
                                                input logic [WEIGHT_W-1:0] w);
    longint      diff;
    longint      prod;
    longint      step;
    logic [63:0] sum;
    if (avg == '0) return sample;
    diff = longint'(sample) - longint'(avg);
    prod = longint'(w) * diff;
    // round half up, arithmetic shift floors negative products
    step = (prod + longint'(ajl_pkg::EMA_ROUND)) >>> ajl_pkg::WEIGHT_SHIFT;
    sum  = longint'(avg) + step;
    return sum[AVG_W-1:0];
  endfunction

  function automatic arrival_result_t predict_arrival(input logic [31:0] now);
    arrival_result_t res;
    logic [31:0]     delta;
    logic [31:0]     gap_q8;
    logic [31:0]     dev;
    logic [31:0]     since_adj;
    logic [63:0]     target;
    logic [63:0]     lat_change;
    res.updated = 1'b0;
    if (!est_seen) begin
      est_seen      = 1'b1;
      est_last_time = now;
    end else begin
      delta         = now - est_last_time;
      est_last_time = now;
      if (delta > GAP_SAT) delta = GAP_SAT;
      gap_q8      = delta << FRAC_BITS;
      est_gap_avg = ema_next(est_gap_avg, gap_q8, est_cfg.alpha);
      dev = (gap_q8 >= est_gap_avg) ? gap_q8 - est_gap_avg : est_gap_avg - gap_q8;
      est_jitter_avg = ema_next(est_jitter_avg, dev, est_cfg.beta);
    end
    if (!est_adj_armed) begin
      est_adj_armed = 1'b1;
      est_adj_time  = now;
    end
    since_adj = now - est_adj_time;
    if (64'(since_adj) >= 64'(est_cfg.period) * ajl_pkg::PERIOD_SCALE) begin
      target = 64'(est_cfg.base_lat)
             + (64'(est_cfg.gain) * 64'(est_jitter_avg)
                + (64'(ajl_pkg::HALF_MS) << FRAC_BITS))
               / (64'(ajl_pkg::PERIOD_SCALE) << FRAC_BITS);
      if (target < 64'(est_cfg.min_lat)) target = 64'(est_cfg.min_lat);
      if (target > 64'(est_cfg.max_lat)) target = 64'(est_cfg.max_lat);
      lat_change = (target >= 64'(est_latency)) ? target - 64'(est_latency)
                                                : 64'(est_latency) - target;
      if (lat_change >= 64'(est_cfg.hyst)) begin
        est_latency = target[LAT_W-1:0];
        res.updated = 1'b1;
      end
      est_adj_time = now;
    end
    res.latency = est_latency;
    res.jitter  = est_jitter_avg;
    res.gap_avg = est_gap_avg;
    return res;
  endfunction

  function automatic int pick_idle();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high after the handshake so back-to-back items need no toggle
  task automatic send_arrival(input logic [31:0] t);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.arrival_time_us <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(predict_arrival(t));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // bits above the register width carry random junk that must be ignored
  task automatic write_reg(input ajl_pkg::cfg_idx_e idx, input logic [CFG_W-1:0] value,
                           input int width);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    for (int b = 0; b < width; b++) data[b] = value[b];
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input ajl_pkg::cfg_t c);
    write_reg(ajl_pkg::CFG_ALPHA,  CFG_W'(c.alpha),    WEIGHT_W);
    write_reg(ajl_pkg::CFG_BETA,   CFG_W'(c.beta),     WEIGHT_W);
    write_reg(ajl_pkg::CFG_BASE,   CFG_W'(c.base_lat), LAT_W);
    write_reg(ajl_pkg::CFG_GAIN,   CFG_W'(c.gain),     GAIN_W);
    write_reg(ajl_pkg::CFG_MIN,    CFG_W'(c.min_lat),  LAT_W);
    write_reg(ajl_pkg::CFG_MAX,    CFG_W'(c.max_lat),  LAT_W);
    write_reg(ajl_pkg::CFG_HYST,   CFG_W'(c.hyst),     HYST_W);
    write_reg(ajl_pkg::CFG_PERIOD, CFG_W'(c.period),   PERIOD_W);
    cfg_we  <= 1'b0;
    est_cfg = c;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd1;
    if (r == 1) return 8'd255;
    return WEIGHT_W'($urandom_range(1, 255));
  endfunction

  function automatic ajl_pkg::cfg_t pick_config();
    ajl_pkg::cfg_t c;
    int            r;
    c.alpha    = pick_weight();
    c.beta     = pick_weight();
    c.base_lat = ($urandom_range(0, 1) == 0) ? LAT_W'($urandom_range(0, 100))
                                             : LAT_W'($urandom_range(0, 1023));
    c.gain     = GAIN_W'($urandom_range(0, 15));
    c.min_lat  = LAT_W'($urandom_range(0, 200));
    // now and then min above max
    c.max_lat  = ($urandom_range(0, 5) == 0) ? LAT_W'($urandom_range(0, 1023))
                                             : LAT_W'($urandom_range(c.min_lat, 1023));
    r = $urandom_range(0, 9);
    if (r < 6) c.hyst = HYST_W'($urandom_range(0, 5));
    else if (r < 9) c.hyst = HYST_W'($urandom_range(6, 40));
    else c.hyst = HYST_W'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 7) c.period = PERIOD_W'($urandom_range(1, 8));
    else if (r < 9) c.period = PERIOD_W'($urandom_range(9, 200));
    else c.period = PERIOD_W'($urandom_range(1, 65535));
    return c;
  endfunction

  task automatic test_reset_defaults();
    // defaults: 1 s adjust period, so span well over a second, wrapping on the way
    next_time = 32'hFFF0_0000;
    for (int i = 0; i < 10; i++) begin
      send_arrival(next_time);
      next_time += $urandom_range(130000, 190000);
    end
    drain();
  endtask

  task automatic test_field_extremes();
    ajl_pkg::cfg_t c;
    logic [31:0]   t;
    c = '{alpha: 8'd255, beta: 8'd255, base_lat: 10'd1023, gain: 4'd15,
          min_lat: 10'd0, max_lat: 10'd1023, hyst: 8'd0, period: 16'd1};
    apply_config(c);
    t = next_time;
    send_arrival(t);
    send_arrival(t);                // zero gap
    t += 1;
    send_arrival(t);
    t += GAP_SAT;                   // largest gap that is not saturated
    send_arrival(t);
    t += GAP_SAT + 1;               // just past it
    send_arrival(t);
    t += 32'h8000_0000;
    send_arrival(t);
    send_arrival(32'hFFFF_FFFF);
    send_arrival(32'h0000_0000);    // wraps with a gap of one
    drain();
    c = '{alpha: 8'd1, beta: 8'd1, base_lat: 10'd0, gain: 4'd0,
          min_lat: 10'd0, max_lat: 10'd0, hyst: 8'd255, period: 16'd65535};
    apply_config(c);
    t = 32'd100;
    send_arrival(t);
    t += 32'd65534999;
    send_arrival(t);
    t += 32'd70000000;
    send_arrival(t);
    next_time = t;
    drain();
  endtask

  task automatic test_zero_weight_and_clamp();
    ajl_pkg::cfg_t c;
    // zero weights freeze both averages, min above max leaves max in force
    c = '{alpha: 8'd0, beta: 8'd0, base_lat: 10'd500, gain: 4'd2,
          min_lat: 10'd800, max_lat: 10'd100, hyst: 8'd5, period: 16'd1};
    apply_config(c);
    for (int i = 0; i < 6; i++) begin
      next_time += $urandom_range(1000, 5000);
      send_arrival(next_time);
    end
    drain();
  endtask

  task automatic test_random_traffic();
    int nominal;
    int r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_config(pick_config());
      steady_flow = (p % 4 == 3);
      nominal = $urandom_range(200, 4000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) next_time += $urandom_range(nominal / 2, nominal * 3 / 2);
        else if (r < 72) next_time += $urandom_range(0, nominal * 8);
        else if (r < 80) next_time += $urandom_range(0, 3);
        else if (r < 88) next_time += $urandom_range(20000, 400000);
        else if (r < 94) next_time += $urandom;
        else next_time = $urandom;
        send_arrival(next_time);
      end
      drain();
      steady_flow = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!steady_flow) begin
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 30) stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    arrival_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("item with nothing expected", 64'(out_ch.latency_ms), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.latency_ms !== want.latency)
          report_mismatch("latency_ms", 64'(out_ch.latency_ms), 64'(want.latency));
        if (out_ch.latency_updated !== want.updated)
          report_mismatch("latency_updated", 64'(out_ch.latency_updated),
                          64'(want.updated));
        if (out_ch.jitter_q8 !== want.jitter)
          report_mismatch("jitter_q8", 64'(out_ch.jitter_q8), 64'(want.jitter));
        if (out_ch.gap_average_q8 !== want.gap_avg)
          report_mismatch("gap_average_q8", 64'(out_ch.gap_average_q8),
                          64'(want.gap_avg));
      end
    end
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.arrival_time_us = '0;
    out_ch.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = ajl_pkg::CFG_ALPHA;
    cfg_data              = '0;
    est_cfg = '{alpha: 8'd26, beta: 8'd51, base_lat: 10'd50, gain: 4'd3,
                min_lat: 10'd50, max_lat: 10'd300, hyst: 8'd10, period: 16'd1000};
    est_seen       = 1'b0;
    est_last_time  = '0;
    est_gap_avg    = '0;
    est_jitter_avg = '0;
    est_latency    = ajl_pkg::LAT_RESET;
    est_adj_armed  = 1'b0;
    est_adj_time   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_zero_weight_and_clamp();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ajl_pkg.sv
rtl/core/ajl_in_if.sv
rtl/core/ajl_out_if.sv
rtl/core/ajl_ctrl.sv
rtl/core/ajl_dp.sv
rtl/core/adaptive_jitter_latency.sv
tb/testbench.sv
